// ===== rtl/sbb_pkg.sv =====
// Package: shared types and constants for the sprite blitter with colour key and blend.
package sbb_pkg;

  localparam logic [23:0] WhiteColour = 24'hFFFFFF;
  localparam logic [7:0]  ChannelMax  = 8'hFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegPosX        = 3'd0,
    RegPosY        = 3'd1,
    RegImageWidth  = 3'd2,
    RegImageHeight = 3'd3,
    RegKeyColor    = 3'd4,
    RegOpacity     = 3'd5,
    RegBlendMode   = 3'd6,
    RegRowPitch    = 3'd7
  } cfg_reg_e;

  // Values of the blend_mode register
  typedef enum logic {
    ModeCopy  = 1'b0,
    ModeBlend = 1'b1
  } blend_mode_e;

  typedef struct packed {
    logic [23:0] source_pixel;
    logic [23:0] screen_pixel;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] frame_address;
    logic [23:0] out_pixel;
    logic        last_pixel;
  } out_t;

  // Placement of one sprite pixel on the screen
  typedef struct packed {
    logic        on_screen;
    logic [11:0] sx;
    logic [11:0] sy;
    logic        last;
  } pos_t;

endpackage

// ===== rtl/sbb_raster.sv =====
// Raster counters, sprite placement and screen clipping for each accepted pixel.
module sbb_raster #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [12:0]        pos_x_i,
  input  logic [12:0]        pos_y_i,
  input  logic [12:0]        image_width_i,
  input  logic [12:0]        image_height_i,
  output sbb_pkg::pos_t      pos_o
);

  localparam logic [12:0] ScrW = 13'(SCREEN_WIDTH);
  localparam logic [12:0] ScrH = 13'(SCREEN_HEIGHT);

  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [11:0] w_last, h_last;
  logic        end_row, end_img;
  logic [11:0] col, row;
  logic signed [13:0] sx, sy;

  // Last column / row index; zero size counts as one, oversize clamps to 4096
  always_comb begin
    if (image_width_i == 13'd0) begin
      w_last = 12'd0;
    end else if (image_width_i > 13'd4096) begin
      w_last = 12'hFFF;
    end else begin
      w_last = 12'(image_width_i - 13'd1);
    end
    if (image_height_i == 13'd0) begin
      h_last = 12'd0;
    end else if (image_height_i > 13'd4096) begin
      h_last = 12'hFFF;
    end else begin
      h_last = 12'(image_height_i - 13'd1);
    end
  end

  assign end_row = col_q >= w_last;
  assign end_img = end_row && (row_q >= h_last);
  assign col     = end_row ? w_last : col_q;
  assign row     = (row_q >= h_last) ? h_last : row_q;

  assign sx = $signed({pos_x_i[12], pos_x_i}) + $signed({2'b00, col});
  assign sy = $signed({pos_y_i[12], pos_y_i}) + $signed({2'b00, row});

  assign pos_o.on_screen = !sx[13] && (sx[12:0] < ScrW) && !sy[13] && (sy[12:0] < ScrH);
  assign pos_o.sx        = sx[11:0];
  assign pos_o.sy        = sy[11:0];
  assign pos_o.last      = end_img;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (end_img) begin
        col_d = 12'd0;
        row_d = 12'd0;
      end else if (end_row) begin
        col_d = 12'd0;
        row_d = row_q + 12'd1;
      end else begin
        col_d = col_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 12'd0;
      row_q <= 12'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // The final pixel of the sprite wraps both counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && end_img |=> col_q == 12'd0 && row_q == 12'd0)
    else $error("raster counters did not wrap after final pixel");

endmodule

// ===== rtl/sbb_pixel.sv =====
// Per-channel saturating additive blend with white override and opacity mix.
module sbb_pixel (
  input  logic [23:0] src_i,
  input  logic [23:0] scr_i,
  input  logic [7:0]  opacity_i,
  output logic [23:0] pix_o
);

  logic white;

  assign white = src_i == sbb_pkg::WhiteColour;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [8:0]         raw;
    logic [7:0]         sum;
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  mix;

    assign raw  = {1'b0, src_i[8*c +: 8]} + {1'b0, scr_i[8*c +: 8]};
    assign sum  = (white || raw[8]) ? sbb_pkg::ChannelMax : raw[7:0];
    assign diff = $signed({1'b0, scr_i[8*c +: 8]}) - $signed({1'b0, sum});
    // sum + floor(op * (screen - sum) / 256)
    assign prod = $signed({1'b0, opacity_i}) * diff;
    assign mix  = $signed({2'b00, sum}) + $signed(prod[17:8]);
    assign pix_o[8*c +: 8] = mix[7:0];
  end

endmodule

// ===== rtl/clipped_sprite_blitter_blend_core.sv =====
// Top level: configuration registers, input and result registers, address and colour logic.
// Sprite blitter: takes one sprite pixel with its framebuffer pixel per clock while in_stall_o
// is low and returns one result per pixel: the pixel is caught in an input register together
// with its clipped screen position, then the address multiply and the colour blend run side by
// side into the result register. Sustained rate is one pixel per clock while out_stall_i is low;
// out_stall_i holds both full registers and reaches in_stall_o in the same cycle. The user must write
// configuration via cfg_we_i/cfg_idx_i/cfg_data_i only while no pixel is in flight; nothing enforces it.
module clipped_sprite_blitter_blend_core #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [23:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sbb_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sbb_pkg::out_t  out_data_o
);

  logic [12:0] pos_x_q, pos_y_q, image_width_q, image_height_q, row_pitch_q;
  logic [23:0] key_color_q;
  logic [7:0]  opacity_q;
  logic        blend_mode_q;

  logic           in_acc, s1_adv;
  logic           s1_valid_q;
  sbb_pkg::in_t   s1_pix_q;
  sbb_pkg::pos_t  s1_pos_q;
  sbb_pkg::pos_t  pos;
  logic           out_valid_q;
  sbb_pkg::out_t  out_q, out_d;
  logic [23:0]    addr_full;
  logic [23:0]    blended;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q        <= 13'd0;
      pos_y_q        <= 13'd0;
      image_width_q  <= 13'd1;
      image_height_q <= 13'd1;
      key_color_q    <= 24'd0;
      opacity_q      <= 8'd0;
      blend_mode_q   <= sbb_pkg::ModeCopy;
      row_pitch_q    <= 13'd1024;
    end else if (cfg_we_i) begin
      unique case (sbb_pkg::cfg_reg_e'(cfg_idx_i))
        sbb_pkg::RegPosX:        pos_x_q        <= cfg_data_i[12:0];
        sbb_pkg::RegPosY:        pos_y_q        <= cfg_data_i[12:0];
        sbb_pkg::RegImageWidth:  image_width_q  <= cfg_data_i[12:0];
        sbb_pkg::RegImageHeight: image_height_q <= cfg_data_i[12:0];
        sbb_pkg::RegKeyColor:    key_color_q    <= cfg_data_i;
        sbb_pkg::RegOpacity:     opacity_q      <= cfg_data_i[7:0];
        sbb_pkg::RegBlendMode:   blend_mode_q   <= cfg_data_i[0];
        sbb_pkg::RegRowPitch:    row_pitch_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Handshake: each register moves on when the one after it is empty or being drained
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  sbb_raster #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_acc),
    .pos_x_i        (pos_x_q),
    .pos_y_i        (pos_y_q),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pos_o          (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= in_data_i;
      s1_pos_q <= pos;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  sbb_pixel u_pixel (
    .src_i     (s1_pix_q.source_pixel),
    .scr_i     (s1_pix_q.screen_pixel),
    .opacity_i (opacity_q),
    .pix_o     (blended)
  );

  // Address wraps at 24 bits
  assign addr_full = 24'(s1_pos_q.sy) * 24'(row_pitch_q) + 24'(s1_pos_q.sx);

  always_comb begin
    out_d.write_enable  = 1'b0;
    out_d.frame_address = 24'd0;
    out_d.out_pixel     = 24'd0;
    out_d.last_pixel    = s1_pos_q.last;
    if (s1_pos_q.on_screen) begin
      out_d.frame_address = addr_full;
      if (blend_mode_q == sbb_pkg::ModeCopy) begin
        out_d.write_enable = 1'b1;
        out_d.out_pixel    = s1_pix_q.source_pixel;
      end else if (s1_pix_q.source_pixel == key_color_q) begin
        // keyed out: screen pixel passes back unchanged
        out_d.out_pixel    = s1_pix_q.screen_pixel;
      end else begin
        out_d.write_enable = 1'b1;
        out_d.out_pixel    = blended;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && out_valid_q)
    else $error("pixel lost from input register under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.write_enable && out_q.out_pixel != 24'd0
      |-> blend_mode_q == sbb_pkg::ModeBlend)
    else $error("keyed result outside blend mode");

endmodule
